// ===== sv/tspl_pkg.sv =====
package tspl_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd2;
    localparam logic [15:0] PASS_MAX        = 16'hFFFF;

    typedef struct packed {
        logic       op;
        logic [4:0] letter;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] prefix_length;
        logic       status;
    } out_word_t;

    // A queued letter, already checked against the alphabet.
    typedef struct packed {
        logic       op;
        logic [4:0] letter;
        logic       letter_ok;
        logic       last;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

endpackage

// ===== sv/tspl_front.sv =====
module tspl_front #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tspl_pkg::in_word_t  in_data,
    input  tspl_pkg::back_ctrl_t ctrl,
    output tspl_pkg::q_head_t   head
);

    tspl_pkg::q_entry_t           fifo_reg [tspl_pkg::QUEUE_DEPTH];
    logic [tspl_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tspl_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tspl_pkg::QCNT_W-1:0]  count_reg, count_next;
    tspl_pkg::q_entry_t           new_entry;
    logic                         push;
    logic                         pop;

    assign in_stall = (count_reg == tspl_pkg::QCNT_W'(tspl_pkg::QUEUE_DEPTH)) || ctrl.clearing;
    assign push     = in_valid && !in_stall;
    assign pop      = ctrl.pop && (count_reg != '0);

    always_comb
    begin
        new_entry.op        = in_data.op;
        new_entry.letter    = in_data.letter;
        new_entry.letter_ok = (32'(in_data.letter) < ALPHABET_SIZE);
        new_entry.last      = in_data.last;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = fifo_reg[rd_ptr_reg];

endmodule

// ===== sv/tspl_back.sv =====
module tspl_back #(
    parameter int NODE_COUNT        = 4096,
    parameter int ALPHABET_SIZE     = 26,
    parameter int MAX_STRING_LENGTH = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [7:0]           cfg_data,
    input  tspl_pkg::q_head_t    head,
    output tspl_pkg::back_ctrl_t ctrl,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tspl_pkg::out_word_t  out_data
);

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int LETTER_W = $clog2(ALPHABET_SIZE);
    localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);
    localparam logic [7:0] MATCH_CAP =
        8'((MAX_STRING_LENGTH < 255) ? MAX_STRING_LENGTH : 255);

    typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_PASS,
        ST_DONE
    } state_t;

    // One row of child pointers per node, and one pass count per node.
    row_t        child_mem [NODE_COUNT];
    logic [15:0] pass_mem  [NODE_COUNT];

    row_t        row_q;
    logic [15:0] pass_q;

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   clr_reg, clr_next;
    tspl_pkg::q_entry_t  cmd_reg, cmd_next;
    logic [NODE_W-1:0]   child_reg, child_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [NODE_W-1:0]   free_reg, free_next;
    logic [7:0]          match_reg, match_next;
    logic                alive_reg, alive_next;
    logic                ovf_reg, ovf_next;
    logic [7:0]          thr_reg, thr_next;
    logic                out_valid_reg, out_valid_next;
    tspl_pkg::out_word_t out_word_reg, out_word_next;

    logic                row_rd;
    logic [NODE_W-1:0]   row_raddr;
    logic                row_we;
    logic [NODE_W-1:0]   row_waddr;
    row_t                row_wdata;
    logic                pass_rd;
    logic [NODE_W-1:0]   pass_raddr;
    logic                pass_we;
    logic [NODE_W-1:0]   pass_waddr;
    logic [15:0]         pass_wdata;

    logic [LETTER_W-1:0] lidx;
    logic [NODE_W-1:0]   row_child;
    logic [NODE_W-1:0]   new_node;
    logic                out_free;
    logic                pop;

    assign lidx      = LETTER_W'(cmd_reg.letter);
    assign row_child = row_q[lidx];
    assign new_node  = free_reg + 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        child_next     = child_reg;
        cursor_next    = cursor_reg;
        free_next      = free_reg;
        match_next     = match_reg;
        alive_next     = alive_reg;
        ovf_next       = ovf_reg;
        thr_next       = cfg_write ? cfg_data : thr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        pop            = 1'b0;
        row_rd         = 1'b0;
        row_raddr      = cursor_reg;
        row_we         = 1'b0;
        row_waddr      = cursor_reg;
        row_wdata      = row_q;
        pass_rd        = 1'b0;
        pass_raddr     = row_child;
        pass_we        = 1'b0;
        pass_waddr     = child_reg;
        pass_wdata     = 16'd1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                row_we    = 1'b1;
                row_waddr = clr_reg;
                row_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == NODE_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head.entry;
                    if (alive_reg && head.entry.letter_ok)
                    begin
                        row_rd     = 1'b1;
                        state_next = ST_ROW;
                    end
                    else
                    begin
                        alive_next = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ROW:
            begin
                state_next = ST_DONE;
                if (row_child == '0)
                begin
                    if (cmd_reg.op == tspl_pkg::OP_QUERY)
                    begin
                        alive_next = 1'b0;
                    end
                    else if (free_reg == NODE_LAST)
                    begin
                        ovf_next   = 1'b1;
                        alive_next = 1'b0;
                    end
                    else
                    begin
                        // New node: link it into the parent row, start its count at one.
                        free_next       = new_node;
                        row_we          = 1'b1;
                        row_wdata       = row_q;
                        row_wdata[lidx] = new_node;
                        pass_we         = 1'b1;
                        pass_waddr      = new_node;
                        pass_wdata      = 16'd1;
                        cursor_next     = new_node;
                    end
                end
                else
                begin
                    child_next = row_child;
                    pass_rd    = 1'b1;
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                state_next = ST_DONE;
                if (cmd_reg.op == tspl_pkg::OP_INSERT)
                begin
                    pass_we     = 1'b1;
                    pass_wdata  = (pass_q == tspl_pkg::PASS_MAX) ? pass_q : pass_q + 1'b1;
                    cursor_next = child_reg;
                end
                else if (pass_q < {8'd0, thr_reg})
                begin
                    alive_next = 1'b0;
                end
                else
                begin
                    cursor_next = child_reg;
                    if (match_reg < MATCH_CAP)
                    begin
                        match_next = match_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!cmd_reg.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_word_next.kind          = cmd_reg.op;
                    out_word_next.prefix_length =
                        (cmd_reg.op == tspl_pkg::OP_QUERY) ? match_reg : 8'd0;
                    out_word_next.status = (cmd_reg.op == tspl_pkg::OP_INSERT) && ovf_reg;
                    cursor_next = '0;
                    match_next  = '0;
                    alive_next  = 1'b1;
                    ovf_next    = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cursor_reg    <= '0;
            free_reg      <= '0;
            match_reg     <= '0;
            alive_reg     <= 1'b1;
            ovf_reg       <= 1'b0;
            thr_reg       <= tspl_pkg::THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cursor_reg    <= cursor_next;
            free_reg      <= free_next;
            match_reg     <= match_next;
            alive_reg     <= alive_next;
            ovf_reg       <= ovf_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        child_reg    <= child_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            child_mem[row_waddr] <= row_wdata;
        end
        if (row_rd)
        begin
            row_q <= child_mem[row_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pass_we)
        begin
            pass_mem[pass_waddr] <= pass_wdata;
        end
        if (pass_rd)
        begin
            pass_q <= pass_mem[pass_raddr];
        end
    end

    assign ctrl.pop      = pop;
    assign ctrl.clearing = (state_reg == ST_CLEAR);
    assign out_valid     = out_valid_reg;
    assign out_data      = out_word_reg;

endmodule

// ===== sv/trie_shared_prefix_length.sv =====
// Prefix trie with shared-prefix counting.
// Input channel (in_valid, in_stall, in_data): one letter per word, tagged as
// insert or query, with a mark on the last letter of each string. A word is
// taken when in_valid is high and in_stall is low.
// Output channel (out_valid, out_stall, out_data): one word at the end of each
// string: the query's shared-prefix length, or the insert's overflow status.
// cfg_write with cfg_data sets the sharing threshold; write it only while idle.
// A four-word queue parts the input side from the trie engine, and a result
// register parts the engine from the output, so a stalled receiver holds the
// result while the queue keeps filling; in_stall rises when the queue is full.
// Per letter the engine goes from idle straight to done when the walk has
// stopped, adds a row state when the child is missing, and adds a row and a
// pass state when a child exists: a registered read of the node's child row,
// then a registered read of the child's pass count. The result word is valid
// right after the engine finishes the last letter of its string.
// After reset the child table is cleared one row a cycle, all NODE_COUNT
// rows, with in_stall held high; the threshold returns to 2.
module trie_shared_prefix_length #(
    parameter int NODE_COUNT        = 4096,
    parameter int ALPHABET_SIZE     = 26,
    parameter int MAX_STRING_LENGTH = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  tspl_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tspl_pkg::out_word_t out_data
);

    tspl_pkg::q_head_t    head;
    tspl_pkg::back_ctrl_t ctrl;

    tspl_front #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data (in_data),
        .ctrl    (ctrl),
        .head    (head)
    );

    tspl_back #(
        .NODE_COUNT       (NODE_COUNT),
        .ALPHABET_SIZE    (ALPHABET_SIZE),
        .MAX_STRING_LENGTH(MAX_STRING_LENGTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data),
        .head     (head),
        .ctrl     (ctrl),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

// ===== sv/tspl_checker.sv =====
module tspl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input tspl_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_stall,
    input tspl_pkg::out_word_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input word changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_insert_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == tspl_pkg::OP_INSERT) |-> out_data.prefix_length == 8'd0)
        else $error("insert result carries a prefix length");

    a_query_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == tspl_pkg::OP_QUERY) |-> !out_data.status)
        else $error("query result carries overflow status");

endmodule

bind trie_shared_prefix_length tspl_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
